### hdl/dawg_word_lookup_macros.svh
// Assertion macros shared by the word lookup modules.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef DAWG_WORD_LOOKUP_MACROS_SVH
`define DAWG_WORD_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DWL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dawg_word_lookup: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DWL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dawg_word_lookup: next-cycle check failed");

`endif

### hdl/dwl_pkg.sv
// ---------------------------------------------------------------------------
// dwl_pkg
// Shared widths, constants and the command/status types that join the
// word lookup controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwl_pkg;

  localparam int TILE_W        = 6;
  localparam int NODE_IN_W     = 16;
  localparam int LEN_W         = 4;
  localparam int LEN_MAX       = 15;
  localparam int MIN_VALID_LEN = 2;

  // Request kinds on req_type.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LETTER = 1'b1;

  typedef struct packed {
    logic write_node;   // store a node record from the input ports
    logic take_letter;  // capture a letter, start the word, count it
    logic start_read;   // begin a sibling scan at the current node
    logic mem_read;     // read the node under the scan pointer
    logic advance;      // step the scan pointer to the next sibling
    logic match_take;   // descend to the matched record's child
    logic fail;         // mark the word as failed
    logic load_result;  // load the output register
    logic clear_word;   // return word state to its start
  } dwl_cmd_t;

  typedef struct packed {
    logic failed;       // word already failed
    logic matched;      // record tile equals the letter
    logic rec_last;     // record is last among its siblings
    logic exhausted;    // scan has read every node
    logic last_letter;  // letter closes the word
    logic out_busy;     // output register holds an untaken result
  } dwl_status_t;

endpackage

### hdl/dwl_datapath.sv
// ---------------------------------------------------------------------------
// dwl_datapath
// Node memory, word walk registers, sibling scan pointer and the output
// register of the word lookup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwl_datapath
  import dwl_pkg::*;
#(
  parameter int NODE_COUNT = 65536,
  parameter int WORD_MAX   = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dwl_cmd_t             cmd,
  output dwl_status_t          status,
  input  logic [NODE_IN_W-1:0] node_addr,
  input  logic [TILE_W-1:0]    node_tile,
  input  logic [NODE_IN_W-1:0] node_child,
  input  logic                 node_last,
  input  logic                 node_accepts,
  input  logic [TILE_W-1:0]    letter,
  input  logic                 word_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 word_valid,
  output logic [LEN_W-1:0]     word_len
);

  `include "dawg_word_lookup_macros.svh"

  localparam int ADDR_W = $clog2(NODE_COUNT);
  localparam int RD_W   = ADDR_W + 1;
  localparam int CNT_W  = $clog2(WORD_MAX + 1);
  localparam int REC_W  = TILE_W + ADDR_W + 2;

  logic [REC_W-1:0]  node_mem [NODE_COUNT];
  logic [REC_W-1:0]  rd_data;

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] wr_child;
  logic [ADDR_W-1:0] root_child;
  logic [ADDR_W-1:0] current_node;
  logic [ADDR_W-1:0] scan_node;
  logic [RD_W-1:0]   read_count;
  logic [CNT_W-1:0]  letter_count;
  logic [TILE_W-1:0] letter_reg;
  logic              last_reg;
  logic              word_failed;
  logic              word_started;
  logic              final_accepts;

  logic [TILE_W-1:0] rd_tile;
  logic [ADDR_W-1:0] rd_child;
  logic              rd_last;
  logic              rd_accepts;

  // Addresses and child indices wrap at the memory size.
  assign wr_addr  = ADDR_W'(node_addr);
  assign wr_child = ADDR_W'(node_child);

  assign rd_tile    = rd_data[TILE_W-1:0];
  assign rd_child   = rd_data[TILE_W +: ADDR_W];
  assign rd_last    = rd_data[TILE_W + ADDR_W];
  assign rd_accepts = rd_data[TILE_W + ADDR_W + 1];

  always_ff @(posedge clk) begin
    if (cmd.write_node) begin
      node_mem[wr_addr] <= {node_accepts, node_last, wr_child, node_tile};
    end
    if (cmd.mem_read) begin
      rd_data <= node_mem[scan_node];
    end
  end

  // Word state and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_node <= '0;
      word_failed  <= 1'b0;
      letter_count <= '0;
      word_started <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.clear_word) begin
        current_node <= '0;
        word_failed  <= 1'b0;
        letter_count <= '0;
        word_started <= 1'b0;
      end else begin
        if (cmd.take_letter) begin
          if (!word_started) begin
            current_node <= root_child;
            word_started <= 1'b1;
          end
          if (letter_count < CNT_W'(WORD_MAX)) begin
            letter_count <= letter_count + 1'b1;
          end
        end
        if (cmd.match_take) begin
          current_node <= rd_child;
        end
        if (cmd.fail) begin
          word_failed <= 1'b1;
        end
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.write_node && (wr_addr == '0)) begin
      root_child <= wr_child;
    end
    if (cmd.take_letter) begin
      letter_reg <= letter;
      last_reg   <= word_last;
    end
    if (cmd.start_read) begin
      scan_node  <= current_node;
      read_count <= '0;
    end else begin
      if (cmd.advance) begin
        scan_node <= scan_node + 1'b1;
      end
      if (cmd.mem_read) begin
        read_count <= read_count + 1'b1;
      end
    end
    if (cmd.match_take) begin
      final_accepts <= rd_accepts;
    end
    if (cmd.load_result) begin
      word_valid <= !word_failed && final_accepts &&
                    (int'(letter_count) >= MIN_VALID_LEN);
      word_len   <= (int'(letter_count) > LEN_MAX) ? LEN_W'(LEN_MAX)
                                                   : LEN_W'(letter_count);
    end
  end

  always_comb begin
    status.failed      = word_failed;
    status.matched     = (rd_tile == letter_reg);
    status.rec_last    = rd_last;
    status.exhausted   = (read_count == RD_W'(NODE_COUNT));
    status.last_letter = last_reg;
    status.out_busy    = out_valid && out_stall;
  end

  `DWL_ASSERT_NOW(a_idle_word_clean, !word_started, (letter_count == '0) && !word_failed)
  `DWL_ASSERT_NEXT(a_clear_resets_word, cmd.clear_word, !word_started && (current_node == '0))

endmodule

### hdl/dwl_ctrl.sv
// ---------------------------------------------------------------------------
// dwl_ctrl
// Sequencer of the word lookup: takes items, runs the sibling scan one node
// read at a time and hands finished words to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwl_ctrl
  import dwl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  dwl_status_t status,
  output dwl_cmd_t    cmd
);

  `include "dawg_word_lookup_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Hold off transfers while in reset or busy with a letter.
  assign in_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          if (req_type == REQ_LOAD) begin
            cmd.write_node = 1'b1;
          end else begin
            cmd.take_letter = 1'b1;
            state_next      = S_START;
          end
        end
      end
      S_START: begin
        // A failed word only counts letters.
        if (status.failed) begin
          state_next = S_END;
        end else begin
          cmd.start_read = 1'b1;
          state_next     = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (status.matched) begin
          cmd.match_take = 1'b1;
          state_next     = S_END;
        end else if (status.rec_last || status.exhausted) begin
          cmd.fail   = 1'b1;
          state_next = S_END;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_END: begin
        if (!status.last_letter) begin
          state_next = S_IDLE;
        end else if (!status.out_busy) begin
          cmd.load_result = 1'b1;
          cmd.clear_word  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `DWL_ASSERT_NOW(a_result_slot_free, cmd.load_result, !status.out_busy)
  `DWL_ASSERT_NEXT(a_read_then_check, state == S_READ, state == S_CHECK)
  `DWL_ASSERT_NOW(a_one_scan_outcome, state == S_CHECK, $onehot({cmd.match_take, cmd.fail, cmd.advance}))

endmodule

### hdl/dawg_word_lookup.sv
// ---------------------------------------------------------------------------
// dawg_word_lookup
// Checks words against a dictionary word graph held in an on-chip node memory.
// ---------------------------------------------------------------------------
// A load item (req_type 0) writes one node record in the cycle it transfers
// and the block is ready again at once. A letter item (req_type 1) passes
// S_START, then S_READ and S_CHECK once per sibling record until a tile match,
// the last sibling or an exhausted scan, then S_END; the node memory has one
// read port with a registered output, so each sibling costs a read state and
// a compare state. Letters of a failed word go from S_START to S_END. On a
// final letter the result goes into an output register; a letter that closes
// a word waits until that register is free, while all other items proceed.
// NODE_COUNT must be a power of two; addresses and child indices wrap at it.
// Node memory content is undefined after reset and needs no clearing pass.
`timescale 1ns / 1ps

module dawg_word_lookup
  import dwl_pkg::*;
#(
  parameter int NODE_COUNT = 65536,
  parameter int WORD_MAX   = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [NODE_IN_W-1:0] node_addr,
  input  logic [TILE_W-1:0]    node_tile,
  input  logic [NODE_IN_W-1:0] node_child,
  input  logic                 node_last,
  input  logic                 node_accepts,
  input  logic [TILE_W-1:0]    letter,
  input  logic                 word_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 word_valid,
  output logic [LEN_W-1:0]     word_len
);

  dwl_cmd_t    cmd;
  dwl_status_t status;

  dwl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  dwl_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .WORD_MAX   (WORD_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .node_addr    (node_addr),
    .node_tile    (node_tile),
    .node_child   (node_child),
    .node_last    (node_last),
    .node_accepts (node_accepts),
    .letter       (letter),
    .word_last    (word_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .word_valid   (word_valid),
    .word_len     (word_len)
  );

endmodule
